>>> sv/assert_macros.svh
// Assertion macros used by the encoder core RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define U8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define U8_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> sv/u8enc_pkg.sv
// Shared types and constants of the UTF-8 code point encoder.
// No dependencies.
`default_nettype none

package u8enc_pkg;

  localparam int unsigned CpW      = 32;
  localparam int unsigned BaseW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 3;
  localparam int unsigned ContW    = 30;
  localparam int unsigned GroupW   = 6;
  // Queue depth must be a power of two; pointers wrap naturally.
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [BaseW-1:0] ReplBaseReset = 16'hDC80;
  localparam logic [BaseW-1:0] ReplEnd       = 16'hDCFF;

  localparam logic [CpW-1:0] Lim1 = 32'h0000_007F;
  localparam logic [CpW-1:0] Lim2 = 32'h0000_07FF;
  localparam logic [CpW-1:0] Lim3 = 32'h0000_FFFF;
  localparam logic [CpW-1:0] Lim4 = 32'h001F_FFFF;
  localparam logic [CpW-1:0] Lim5 = 32'h03FF_FFFF;
  localparam logic [CpW-1:0] Lim6 = 32'h7FFF_FFFF;

  localparam logic [ByteW-1:0] Lead2   = 8'hC0;
  localparam logic [ByteW-1:0] Lead3   = 8'hE0;
  localparam logic [ByteW-1:0] Lead4   = 8'hF0;
  localparam logic [ByteW-1:0] Lead5   = 8'hF8;
  localparam logic [ByteW-1:0] Lead6   = 8'hFC;
  localparam logic [1:0]       ContTag = 2'b10;

  // One classified code point: lead byte, continuation groups packed from
  // the top down, and the total byte count (1 to 6).
  typedef struct packed {
    logic [ByteW-1:0] lead;
    logic [ContW-1:0] cont;
    logic [PosW-1:0]  nbytes;
  } entry_t;

endpackage

`default_nettype wire

>>> sv/utf8_code_point_encoder_core.sv
// Flow: an accepted request is written into the queue, then its lead byte is loaded
// into the output register once the serializer is free.
// Throughput: one request per cycle for single-byte results while the output is not
// stalled; a code point of n bytes holds the output serializer for its n bytes, one byte per cycle.
// Reset: empties the queue and output register, replacement base to 0xDC80.
// Depends on u8enc_pkg, u8enc_front, u8enc_queue, u8enc_back, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module utf8_code_point_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // replacement_base
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] code_point
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [7:0] out_byte, [10:8] byte_position, rest 0
  output logic             m_axis_tlast_o   // last_byte
);

  logic              q_full, q_push, q_pop, q_valid;
  u8enc_pkg::entry_t push_entry, head_entry;
  logic [7:0]        out_byte;
  logic [2:0]        out_pos;
  logic              out_fire;

  u8enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cp_i     (s_axis_tdata_i),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready_o),
    .push_o      (q_push),
    .entry_o     (push_entry)
  );

  u8enc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  u8enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (out_byte),
    .out_pos_o   (out_pos),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, out_pos, out_byte};
  assign out_fire       = m_axis_tvalid_o && m_axis_tready_i;

  `U8_ASSERT(a_pos_range, m_axis_tvalid_o |-> (out_pos <= 3'd5))
  `U8_ASSERT(a_next_pos, (out_fire && !m_axis_tlast_o) |=> (out_pos == $past(out_pos) + 3'd1))
  `U8_ASSERT(a_cont_tag, (m_axis_tvalid_o && out_pos != 3'd0) |-> (out_byte[7:6] == u8enc_pkg::ContTag))
  `U8_ASSERT_NEVER(a_pop_empty, q_pop && !q_valid)

endmodule

`default_nettype wire

>>> sv/u8enc_front.sv
// Front end: holds the replacement base register and classifies each
// accepted code point into a queue entry. Depends on u8enc_pkg.
`default_nettype none

module u8enc_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [u8enc_pkg::BaseW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  input  wire logic [u8enc_pkg::CpW-1:0]  in_cp_i,
  input  wire logic                       q_full_i,
  output logic                            in_ready_o,
  output logic                            push_o,
  output u8enc_pkg::entry_t               entry_o
);

  logic [u8enc_pkg::BaseW-1:0] base_q, base_d;
  logic                        emit;

  always_comb begin
    base_d = base_q;
    if (cfg_we_i) begin
      base_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= u8enc_pkg::ReplBaseReset;
    end else begin
      base_q <= base_d;
    end
  end

  always_comb begin
    emit           = 1'b1;
    entry_o.lead   = '0;
    entry_o.cont   = '0;
    entry_o.nbytes = 3'd1;
    priority if (in_cp_i <= u8enc_pkg::Lim1) begin
      entry_o.lead = in_cp_i[7:0];
    end else if (in_cp_i <= u8enc_pkg::Lim2) begin
      entry_o.lead   = u8enc_pkg::Lead2 | {3'b000, in_cp_i[10:6]};
      entry_o.cont   = {in_cp_i[5:0], 24'd0};
      entry_o.nbytes = 3'd2;
    end else if (in_cp_i <= u8enc_pkg::Lim3) begin
      if (in_cp_i[15:0] >= base_q && in_cp_i[15:0] <= u8enc_pkg::ReplEnd) begin
        // raw byte stand-in: low byte only
        entry_o.lead = in_cp_i[7:0];
      end else begin
        entry_o.lead   = u8enc_pkg::Lead3 | {4'b0000, in_cp_i[15:12]};
        entry_o.cont   = {in_cp_i[11:0], 18'd0};
        entry_o.nbytes = 3'd3;
      end
    end else if (in_cp_i <= u8enc_pkg::Lim4) begin
      entry_o.lead   = u8enc_pkg::Lead4 | {5'b00000, in_cp_i[20:18]};
      entry_o.cont   = {in_cp_i[17:0], 12'd0};
      entry_o.nbytes = 3'd4;
    end else if (in_cp_i <= u8enc_pkg::Lim5) begin
      entry_o.lead   = u8enc_pkg::Lead5 | {6'b000000, in_cp_i[25:24]};
      entry_o.cont   = {in_cp_i[23:0], 6'd0};
      entry_o.nbytes = 3'd5;
    end else if (in_cp_i <= u8enc_pkg::Lim6) begin
      entry_o.lead   = u8enc_pkg::Lead6 | {7'b0000000, in_cp_i[30]};
      entry_o.cont   = in_cp_i[29:0];
      entry_o.nbytes = 3'd6;
    end else begin
      // out of range: drop the request
      emit = 1'b0;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && emit;

endmodule

`default_nettype wire

>>> sv/u8enc_queue.sv
// Short entry queue between classifier and byte serializer.
// Depends on u8enc_pkg.
`default_nettype none

module u8enc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire u8enc_pkg::entry_t entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output u8enc_pkg::entry_t      entry_o
);

  u8enc_pkg::entry_t             mem_q [u8enc_pkg::QDepth];
  logic [u8enc_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [u8enc_pkg::QPtrW:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (u8enc_pkg::QPtrW+1)'(u8enc_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + u8enc_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + u8enc_pkg::QPtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + (u8enc_pkg::QPtrW+1)'(1);
      2'b01:   cnt_d = cnt_q - (u8enc_pkg::QPtrW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/u8enc_back.sv
// Back end: takes queue entries and sends their bytes one per cycle, unless the
// output stalls, through the output register. Depends on u8enc_pkg.
`default_nettype none

module u8enc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire u8enc_pkg::entry_t           q_entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [u8enc_pkg::ByteW-1:0]      out_byte_o,
  output logic [u8enc_pkg::PosW-1:0]       out_pos_o,
  output logic                             out_last_o
);

  logic                         valid_q, valid_d;
  logic [u8enc_pkg::ByteW-1:0]  byte_q, byte_d;
  logic [u8enc_pkg::PosW-1:0]   pos_q, pos_d, n_q, n_d;
  logic                         last_q, last_d;
  logic [u8enc_pkg::ContW-1:0]  cont_q, cont_d;
  logic                         load, advance;

  assign advance = valid_q && out_ready_i && !last_q;
  assign load    = !valid_q || (out_ready_i && last_q);
  assign pop_o   = load && q_valid_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    pos_d   = pos_q;
    n_d     = n_q;
    last_d  = last_q;
    cont_d  = cont_q;
    if (advance) begin
      // next continuation byte from the top group, then shift it out
      byte_d = {u8enc_pkg::ContTag,
                cont_q[u8enc_pkg::ContW-1 -: u8enc_pkg::GroupW]};
      cont_d = {cont_q[u8enc_pkg::ContW-u8enc_pkg::GroupW-1:0],
                {u8enc_pkg::GroupW{1'b0}}};
      pos_d  = pos_q + 3'd1;
      last_d = (pos_q + 3'd2 == n_q);
    end else if (load) begin
      valid_d = q_valid_i;
      byte_d  = q_entry_i.lead;
      cont_d  = q_entry_i.cont;
      n_d     = q_entry_i.nbytes;
      pos_d   = '0;
      last_d  = (q_entry_i.nbytes == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    pos_q  <= pos_d;
    n_q    <= n_d;
    last_q <= last_d;
    cont_q <= cont_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_pos_o   = pos_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench of utf8_code_point_encoder_core: code points go in, encoded bytes are
// compared against typed rows or an in-bench encoder across several base settings.
// Depends on u8enc_pkg and the encoder RTL.
`default_nettype none

module tb_top;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  typedef struct packed {
    logic [7:0] octet;
    logic [2:0] pos;
    logic       last;
  } enc_byte_t;

  // One directed row: code point, whether the bytes are typed in, their count
  // and the bytes themselves, lead byte leftmost.
  typedef struct packed {
    logic [31:0]     cp;
    logic            typed;
    logic [2:0]      n;
    logic [0:5][7:0] seq;
  } stim_row_t;

  enc_byte_t   pending_bytes[$];
  stim_row_t   stim_rows[24];
  logic [15:0] repl_base_model = u8enc_pkg::ReplBaseReset;
  logic        quiet           = 1'b0;
  int          mismatches      = 0;
  int          bytes_seen      = 0;
  int          points_sent     = 0;
  int          stall_left      = 0;

  utf8_code_point_encoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("utf8_code_point_encoder_core regression: fail");
    $finish;
  end

  function automatic void push_byte(input logic [7:0] octet, input int k, input bit last);
    enc_byte_t b;
    b.octet = octet;
    b.pos   = 3'(k);
    b.last  = last;
    pending_bytes.push_back(b);
  endfunction

  // Expected bytes of one code point under the current replacement base.
  function automatic void encode_code_point(input logic [31:0] cp);
    logic [7:0] lead;
    int         n;
    if (cp <= u8enc_pkg::Lim1) begin
      push_byte(cp[7:0], 0, 1'b1);
      return;
    end
    if (cp <= u8enc_pkg::Lim2) begin
      n    = 2;
      lead = u8enc_pkg::Lead2 | 8'(cp >> 6);
    end else if (cp <= u8enc_pkg::Lim3) begin
      // raw-byte range only applies to the three-byte class
      if (cp[15:0] >= repl_base_model && cp[15:0] <= u8enc_pkg::ReplEnd) begin
        push_byte(cp[7:0], 0, 1'b1);
        return;
      end
      n    = 3;
      lead = u8enc_pkg::Lead3 | 8'(cp >> 12);
    end else if (cp <= u8enc_pkg::Lim4) begin
      n    = 4;
      lead = u8enc_pkg::Lead4 | {5'b0, cp[20:18]};
    end else if (cp <= u8enc_pkg::Lim5) begin
      n    = 5;
      lead = u8enc_pkg::Lead5 | {6'b0, cp[25:24]};
    end else if (cp <= u8enc_pkg::Lim6) begin
      n    = 6;
      lead = u8enc_pkg::Lead6 | {7'b0, cp[30]};
    end else begin
      return;
    end
    push_byte(lead, 0, 1'b0);
    for (int k = 1; k < n; k++) begin
      logic [31:0] grp;
      grp = cp >> (6 * (n - 1 - k));
      push_byte({u8enc_pkg::ContTag, grp[5:0]}, k, k == n - 1);
    end
  endfunction

  function automatic logic [31:0] pick_code_point();
    int lo;
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($urandom_range(0, 32'h7F));
      3:       return 32'($urandom_range(32'h80, 32'h7FF));
      4:       return 32'($urandom_range(32'h800, 32'hFFFF));
      5: begin
        // crowd the edges of the raw-byte range
        if (repl_base_model > u8enc_pkg::ReplEnd) lo = 32'hDC00;
        else if (repl_base_model < 4) lo = 0;
        else lo = int'(repl_base_model) - 4;
        return 32'($urandom_range(lo, 32'hDD03));
      end
      6:       return 32'($urandom_range(32'h1_0000, 32'h1F_FFFF));
      7:       return 32'($urandom_range(32'h20_0000, 32'h3FF_FFFF));
      8:       return 32'($urandom_range(32'h400_0000, 32'h7FFF_FFFF));
      default: return $urandom();
    endcase
  endfunction

  // Present one request and hold it until accepted; optional idle burst first.
  task automatic send_code_point(input logic [31:0] cp);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i  = $urandom();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = cp;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    points_sent++;
  endtask

  // Drop the request, let every expected byte arrive, then allow for a
  // request with no output still in flight.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_replacement_base(input logic [15:0] base);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = base;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    repl_base_model = base;
  endtask

  task automatic run_random(input int count);
    logic [31:0] cp;
    for (int i = 0; i < count; i++) begin
      cp = pick_code_point();
      send_code_point(cp);
      encode_code_point(cp);
    end
  endtask

  // Output side: random stall bursts, none once quiet.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i = 1'b0;
        stall_left      = $urandom_range(1, 18) - 1;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte %h", m_axis_tdata_o[7:0]);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata_o[7:0] !== want.octet) begin
          $error("out_byte: expected %h, got %h", want.octet, m_axis_tdata_o[7:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[10:8] !== want.pos) begin
          $error("byte_position: expected %0d, got %0d", want.pos, m_axis_tdata_o[10:8]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_byte: expected %b, got %b", want.last, m_axis_tlast_o);
          mismatches++;
        end
        if (m_axis_tdata_o[15:11] !== 5'b0) begin
          $error("tdata padding: expected 00, got %h", m_axis_tdata_o[15:11]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_rows = '{
      {32'h0000_0000, 1'b1, 3'd1, 48'h00_00_00_00_00_00},  // U+0000, single byte
      {32'h0000_007F, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
      {32'h0000_0041, 1'b0, 3'd0, 48'h0},
      {32'h0000_0080, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
      {32'h0000_07FF, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
      {32'h0000_0800, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
      {32'h0000_20AC, 1'b0, 3'd0, 48'h0},
      {32'h0000_DC7F, 1'b0, 3'd0, 48'h0},
      {32'h0000_DC80, 1'b1, 3'd1, 48'h80_00_00_00_00_00},  // raw byte, range start
      {32'h0000_DCAB, 1'b0, 3'd0, 48'h0},
      {32'h0000_DCFF, 1'b1, 3'd1, 48'hFF_00_00_00_00_00},  // raw byte, range end
      {32'h0000_DD00, 1'b0, 3'd0, 48'h0},
      {32'h0000_FFFF, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
      {32'h0001_0000, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
      {32'h0001_F600, 1'b0, 3'd0, 48'h0},
      {32'h001F_FFFF, 1'b1, 3'd4, 48'hF7_BF_BF_BF_00_00},
      {32'h0020_0000, 1'b1, 3'd5, 48'hF8_88_80_80_80_00},
      {32'h03FF_FFFF, 1'b1, 3'd5, 48'hFB_BF_BF_BF_BF_00},
      {32'h0400_0000, 1'b1, 3'd6, 48'hFC_84_80_80_80_80},
      {32'h7FFF_FFFF, 1'b1, 3'd6, 48'hFD_BF_BF_BF_BF_BF},
      {32'h1234_5678, 1'b0, 3'd0, 48'h0},
      {32'h8000_0000, 1'b1, 3'd0, 48'h0},                  // too large: no output
      {32'hFFFF_FFFF, 1'b1, 3'd0, 48'h0},
      {32'h5555_5555, 1'b0, 3'd0, 48'h0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset base 0xDC80
    foreach (stim_rows[i]) begin
      send_code_point(stim_rows[i].cp);
      if (stim_rows[i].typed) begin
        for (int k = 0; k < int'(stim_rows[i].n); k++)
          push_byte(stim_rows[i].seq[k], k, k == int'(stim_rows[i].n) - 1);
      end else begin
        encode_code_point(stim_rows[i].cp);
      end
    end
    run_random(110);

    set_replacement_base(16'h0000);
    run_random(80);
    set_replacement_base(u8enc_pkg::ReplEnd);
    run_random(70);
    // base above the range end leaves the range empty
    set_replacement_base(16'hFFFF);
    run_random(60);
    set_replacement_base(16'($urandom_range(32'h0800, 32'hDCFF)));
    quiet = 1'b1;
    run_random(60);

    drain();
    $display("Sent %0d code points through five replacement base settings; %0d bytes checked.",
             points_sent, bytes_seen);
    if (mismatches == 0) begin
      $display("utf8_code_point_encoder_core regression: pass");
    end else begin
      $display("utf8_code_point_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
